[hdl/script_text_minifier_defines.svh]
// ---------------------------------------------------------------------------
// Script text minifier assertion macros
// Shared concurrent assertion forms for the minifier RTL.
// ---------------------------------------------------------------------------
`ifndef SCRIPT_TEXT_MINIFIER_DEFINES_SVH
`define SCRIPT_TEXT_MINIFIER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/stm_pkg.sv]
// ---------------------------------------------------------------------------
// Script text minifier package
// Character codes, lexer contexts, queue command type and helper functions.
// ---------------------------------------------------------------------------
package stm_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int PREFIX_LEN  = 11;
  localparam int CMD_BYTES   = 3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [7:0] {
    CTX_NORMAL   = 8'b0000_0001,
    CTX_SLASH    = 8'b0000_0010,
    CTX_SQUOTE   = 8'b0000_0100,
    CTX_DQUOTE   = 8'b0000_1000,
    CTX_TEMPLATE = 8'b0001_0000,
    CTX_LINE     = 8'b0010_0000,
    CTX_BLOCK    = 8'b0100_0000,
    CTX_REGEX    = 8'b1000_0000
  } stm_ctx_t;

  typedef struct packed {
    logic                      pfx;
    logic [1:0]                cnt;
    logic [CMD_BYTES-1:0][7:0] data;
  } stm_cmd_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return c inside {[CH_0:CH_9], [CH_UA:CH_UZ], [CH_LA:CH_LZ]};
  endfunction

  function automatic logic regex_may_follow(input logic [7:0] t);
    return t inside {CH_LPAREN, CH_COMMA, CH_EQUAL, CH_COLON, CH_LBRACK, CH_BANG,
                     CH_AMP, CH_PIPE, CH_QMARK, CH_LBRACE, CH_RBRACE, CH_SEMI,
                     CH_LF, CH_NUL};
  endfunction

  function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h6A;
      4'd1:    b = 8'h61;
      4'd2:    b = 8'h76;
      4'd3:    b = 8'h61;
      4'd4:    b = 8'h73;
      4'd5:    b = 8'h63;
      4'd6:    b = 8'h72;
      4'd7:    b = 8'h69;
      4'd8:    b = 8'h70;
      4'd9:    b = 8'h74;
      4'd10:   b = CH_COLON;
      default: b = CH_NUL;
    endcase
    return b;
  endfunction

endpackage

[hdl/script_text_minifier.sv]
// ---------------------------------------------------------------------------
// Script text minifier
// Byte-stream minifier for script text with a lexer front end, a command
// queue and a byte-serial back end.
// ---------------------------------------------------------------------------
// The input side takes one source byte or end-of-stream beat per cycle while
// the command queue (QUEUE_DEPTH entries) has room; each beat becomes at most
// one queue command. The output port then sends one byte per cycle while
// out_tready is high and a command waits; an input beat yields zero to two
// bytes for a source byte, two at most after a pending slash, eleven more on
// the first beat of a stream for the "javascript:" prefix, and one or two at
// end of stream. The output port's one byte per cycle sets the sustained
// rate; beats that write nothing, such as whitespace and comment text, add
// no output bytes. Each run of output bytes ends with tlast set.
// ---------------------------------------------------------------------------
`include "script_text_minifier_defines.svh"

module script_text_minifier #(
  parameter int QUEUE_DEPTH = stm_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic [0:0] in_tuser,   // [0] mode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // run_last
);

  stm_pkg::stm_cmd_t                   q_cmd;
  stm_pkg::stm_cmd_t                   q_head;
  logic                                q_push;
  logic                                q_pop;
  logic                                q_full;
  logic                                q_not_empty;
  logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_level;
  logic [3:0]                          back_pos;
  logic                                eos_acc;
  logic                                q_busy;

  assign eos_acc = in_tvalid && in_tready && in_tuser[0];
  assign q_busy  = (q_level != '0);

  stm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  stm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_cmd    (q_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full),
    .level     (q_level)
  );

  stm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_not_empty),
    .pop        (q_pop),
    .pos        (back_pos),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `STM_ASSERT_NEXT(a_eos_queued, eos_acc, q_busy, "End of stream left no command")
  `STM_ASSERT_SAME(a_pos_cmd, back_pos != 4'd0, q_not_empty, "Back end busy with empty queue")
  `STM_ASSERT_SAME(a_run_held, out_tvalid && !out_tlast, q_busy, "Command popped too early")

endmodule

[hdl/stm_front.sv]
// ---------------------------------------------------------------------------
// Script text minifier front end
// Tracks the lexer context per input beat and issues at most one queue command
// that holds the optional prefix flag and up to two literal output bytes.
// ---------------------------------------------------------------------------
module stm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] char_in
  input  logic [0:0]       in_tuser,   // [0] mode
  input  logic             q_full,
  output logic             q_push,
  output stm_pkg::stm_cmd_t q_cmd
);

  stm_pkg::stm_ctx_t ctx_r, ctx_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic [7:0] le_r, le_nxt;
  logic [7:0] ls_r, ls_nxt;
  logic       sp_r, sp_nxt;
  logic       als_r, als_nxt;
  logic       ps_r, ps_nxt;

  logic [2:0][7:0] ob;
  logic [1:0]      cnt;
  logic            run_nb;
  logic            keep_slash;
  logic            esc;
  logic [7:0]      c;
  logic            acc;

  assign c         = in_tdata;
  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    ctx_nxt    = ctx_r;
    prev_nxt   = prev_r;
    le_nxt     = le_r;
    ls_nxt     = ls_r;
    sp_nxt     = sp_r;
    als_nxt    = als_r;
    ps_nxt     = 1'b1;
    ob         = '0;
    cnt        = 2'd0;
    run_nb     = 1'b0;
    keep_slash = 1'b0;
    esc        = 1'b0;
    if (in_tuser[0]) begin
      if (ctx_r == stm_pkg::CTX_SLASH) begin
        ob[cnt] = stm_pkg::CH_SLASH;
        cnt     = cnt + 2'd1;
      end
      ob[cnt]  = stm_pkg::CH_LF;
      cnt      = cnt + 2'd1;
      ctx_nxt  = stm_pkg::CTX_NORMAL;
      prev_nxt = stm_pkg::CH_NUL;
      le_nxt   = stm_pkg::CH_NUL;
      ls_nxt   = stm_pkg::CH_NUL;
      sp_nxt   = 1'b0;
      als_nxt  = 1'b1;
      ps_nxt   = 1'b0;
    end else begin
      case (ctx_r)
        stm_pkg::CTX_NORMAL: begin
          run_nb = 1'b1;
        end
        stm_pkg::CTX_SLASH: begin
          if (c == stm_pkg::CH_SLASH) begin
            ctx_nxt    = stm_pkg::CTX_LINE;
            keep_slash = 1'b1;
          end else if (c == stm_pkg::CH_STAR) begin
            ctx_nxt    = stm_pkg::CTX_BLOCK;
            keep_slash = 1'b1;
          end else if (stm_pkg::regex_may_follow(ls_r)) begin
            ob[cnt]    = stm_pkg::CH_SLASH;
            cnt        = cnt + 2'd1;
            ob[cnt]    = c;
            cnt        = cnt + 2'd1;
            ctx_nxt    = stm_pkg::CTX_REGEX;
            ls_nxt     = stm_pkg::CH_NUL;
            als_nxt    = 1'b0;
            keep_slash = 1'b1;
          end else begin
            ctx_nxt  = stm_pkg::CTX_NORMAL;
            ob[cnt]  = stm_pkg::CH_SLASH;
            cnt      = cnt + 2'd1;
            sp_nxt   = 1'b0;
            le_nxt   = stm_pkg::CH_SLASH;
            ls_nxt   = stm_pkg::CH_SLASH;
            als_nxt  = 1'b0;
            prev_nxt = stm_pkg::CH_SLASH;
            run_nb   = 1'b1;
          end
        end
        stm_pkg::CTX_SQUOTE: begin
          ob[cnt] = c;
          cnt     = cnt + 2'd1;
          if (c == stm_pkg::CH_SQUOTE && prev_r != stm_pkg::CH_BSLASH) begin
            ctx_nxt = stm_pkg::CTX_NORMAL;
            ls_nxt  = c;
          end
        end
        stm_pkg::CTX_DQUOTE: begin
          ob[cnt] = c;
          cnt     = cnt + 2'd1;
          if (c == stm_pkg::CH_DQUOTE && prev_r != stm_pkg::CH_BSLASH) begin
            ctx_nxt = stm_pkg::CTX_NORMAL;
            ls_nxt  = c;
          end
        end
        stm_pkg::CTX_TEMPLATE: begin
          if (c == stm_pkg::CH_LF) begin
            ob[cnt] = stm_pkg::CH_BSLASH;
            cnt     = cnt + 2'd1;
            ob[cnt] = stm_pkg::CH_LN;
            cnt     = cnt + 2'd1;
          end else begin
            ob[cnt] = c;
            cnt     = cnt + 2'd1;
          end
          if (c == stm_pkg::CH_BTICK && prev_r != stm_pkg::CH_BSLASH) begin
            ctx_nxt = stm_pkg::CTX_NORMAL;
            ls_nxt  = c;
          end
        end
        stm_pkg::CTX_LINE: begin
          if (c == stm_pkg::CH_LF) begin
            ctx_nxt = stm_pkg::CTX_NORMAL;
            als_nxt = 1'b1;
          end
        end
        stm_pkg::CTX_BLOCK: begin
          if (c == stm_pkg::CH_SLASH && prev_r == stm_pkg::CH_STAR) begin
            ctx_nxt = stm_pkg::CTX_NORMAL;
          end
        end
        stm_pkg::CTX_REGEX: begin
          ob[cnt] = c;
          cnt     = cnt + 2'd1;
          if (c == stm_pkg::CH_SLASH && prev_r != stm_pkg::CH_BSLASH) begin
            ctx_nxt = stm_pkg::CTX_NORMAL;
            ls_nxt  = c;
          end
        end
        default: begin
          ctx_nxt = stm_pkg::CTX_NORMAL;
        end
      endcase

      if (run_nb) begin
        esc = (prev_nxt == stm_pkg::CH_BSLASH);
        if (c == stm_pkg::CH_SLASH && !esc) begin
          ctx_nxt = stm_pkg::CTX_SLASH;
        end else if (c == stm_pkg::CH_SQUOTE && !esc) begin
          ctx_nxt = stm_pkg::CTX_SQUOTE;
          ob[cnt] = c;
          cnt     = cnt + 2'd1;
          ls_nxt  = c;
          als_nxt = 1'b0;
        end else if (c == stm_pkg::CH_DQUOTE && !esc) begin
          ctx_nxt = stm_pkg::CTX_DQUOTE;
          ob[cnt] = c;
          cnt     = cnt + 2'd1;
          ls_nxt  = c;
          als_nxt = 1'b0;
        end else if (c == stm_pkg::CH_BTICK) begin
          ctx_nxt = stm_pkg::CTX_TEMPLATE;
          ob[cnt] = c;
          cnt     = cnt + 2'd1;
          ls_nxt  = c;
          als_nxt = 1'b0;
        end else if (stm_pkg::is_ws(c)) begin
          if (!als_nxt && prev_nxt != stm_pkg::CH_NUL && !stm_pkg::is_ws(prev_nxt)) begin
            sp_nxt = 1'b1;
          end
        end else begin
          if (sp_nxt && stm_pkg::is_alnum(c) && stm_pkg::is_alnum(le_nxt)) begin
            ob[cnt] = stm_pkg::CH_SPACE;
            cnt     = cnt + 2'd1;
          end
          ob[cnt] = c;
          cnt     = cnt + 2'd1;
          sp_nxt  = 1'b0;
          le_nxt  = c;
          ls_nxt  = c;
          als_nxt = 1'b0;
        end
      end

      prev_nxt = keep_slash ? stm_pkg::CH_SLASH : c;
    end
  end

  assign q_cmd.pfx  = !ps_r;
  assign q_cmd.cnt  = cnt;
  assign q_cmd.data = ob;
  assign q_push     = acc && (!ps_r || cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r  <= stm_pkg::CTX_NORMAL;
      prev_r <= stm_pkg::CH_NUL;
      le_r   <= stm_pkg::CH_NUL;
      ls_r   <= stm_pkg::CH_NUL;
      sp_r   <= 1'b0;
      als_r  <= 1'b1;
      ps_r   <= 1'b0;
    end else if (acc) begin
      ctx_r  <= ctx_nxt;
      prev_r <= prev_nxt;
      le_r   <= le_nxt;
      ls_r   <= ls_nxt;
      sp_r   <= sp_nxt;
      als_r  <= als_nxt;
      ps_r   <= ps_nxt;
    end
  end

endmodule

[hdl/stm_fifo.sv]
// ---------------------------------------------------------------------------
// Script text minifier command queue
// Small register queue of output commands between the front and back ends.
// ---------------------------------------------------------------------------
module stm_fifo #(
  parameter int DEPTH = stm_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  stm_pkg::stm_cmd_t               wr_cmd,
  input  logic                            pop,
  output stm_pkg::stm_cmd_t               head,
  output logic                            not_empty,
  output logic                            full,
  output logic [$clog2(DEPTH+1)-1:0]      level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH+1);

  stm_pkg::stm_cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (level_r != '0);
  assign full      = (level_r == LVL_W'(DEPTH));
  assign level     = level_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

[hdl/stm_back.sv]
// ---------------------------------------------------------------------------
// Script text minifier back end
// Expands the queue head command into output beats, one byte per cycle,
// into a registered output stage that out_tready back-pressure can stall.
// ---------------------------------------------------------------------------
module stm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  stm_pkg::stm_cmd_t head,
  input  logic              head_valid,
  output logic              pop,
  output logic [3:0]        pos,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] out_byte
  output logic              out_tlast   // run_last
);

  logic [3:0] pos_r, pos_nxt;
  logic       vld_r;
  logic [7:0] data_r;
  logic       last_r;
  logic       adv;
  logic       fire;
  logic [3:0] off;
  logic [3:0] sel;
  logic [3:0] last_pos;
  logic       is_last;
  logic [7:0] byte_val;

  assign adv      = !vld_r || out_tready;
  assign fire     = adv && head_valid;
  assign off      = head.pfx ? 4'(stm_pkg::PREFIX_LEN) : 4'd0;
  assign sel      = pos_r - off;
  assign last_pos = off + {2'b00, head.cnt} - 4'd1;
  assign is_last  = (pos_r == last_pos);
  assign byte_val = (head.pfx && pos_r < 4'(stm_pkg::PREFIX_LEN)) ?
                    stm_pkg::prefix_byte(pos_r) : head.data[sel[1:0]];
  assign pop      = fire && is_last;
  assign pos_nxt  = is_last ? 4'd0 : pos_r + 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 4'd0;
      vld_r <= 1'b0;
    end else if (fire) begin
      pos_r <= pos_nxt;
      vld_r <= 1'b1;
    end else if (adv) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      data_r <= byte_val;
      last_r <= is_last;
    end
  end

  assign pos        = pos_r;
  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule
